### sv/fycs_pkg.sv
package fycs_pkg;

    localparam int WORD_W = 31;
    localparam int HAND_W = 6;
    localparam int CODE_W = 6;
    localparam int SUIT_W = 2;
    localparam int RANK_W = 4;

endpackage

### sv/fycs_ram.sv
module fycs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/fisher_yates_card_shuffler_unit.sv
// channel   ports                              transaction when
// input     start, busy, random_word           start high, busy low
// config    cfg_we, cfg_wdata                  cfg_we high
// output    card_valid, card_code, suit,       card_valid high, one cycle each
//           rank, last_card
//
// a shuffle step runs from one accepted transaction to the next through the idle
// state that accepts it, the bit-serial remainder in ST_DIV and the swap through the
// single read / single write deck memory in ST_RD_POS, ST_RD_PART, ST_WR_POS, ST_WR_PART
// the final step deals the hand at one card per cycle via the memory read and output registers
// reset leaves the deck as identity via per-entry valid bits, no clearing pass
// results cannot be held off; busy covers the whole step and the deal reads
module fisher_yates_card_shuffler_unit #(
    parameter int SUIT_COUNT     = 4,
    parameter int RANKS_PER_SUIT = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fycs_pkg::WORD_W-1:0]   random_word,
    input  logic                          cfg_we,
    input  logic [fycs_pkg::HAND_W-1:0]   cfg_wdata,
    output logic                          card_valid,
    output logic [fycs_pkg::CODE_W-1:0]   card_code,
    output logic [fycs_pkg::SUIT_W-1:0]   suit,
    output logic [fycs_pkg::RANK_W-1:0]   rank,
    output logic                          last_card
);

    import fycs_pkg::*;

    localparam int DECK_SIZE = SUIT_COUNT * RANKS_PER_SUIT;
    localparam int AW        = $clog2(DECK_SIZE);
    localparam int CW        = AW + 1;
    localparam int BCW       = $clog2(WORD_W);
    localparam logic [CW-1:0]     DECK_C  = CW'(DECK_SIZE);
    localparam logic [AW-1:0]     TOP_POS = AW'(DECK_SIZE - 1);
    localparam logic [CODE_W:0]   R1      = (CODE_W+1)'(RANKS_PER_SUIT);
    localparam logic [CODE_W:0]   R2      = (CODE_W+1)'(2 * RANKS_PER_SUIT);
    localparam logic [CODE_W:0]   R3      = (CODE_W+1)'(3 * RANKS_PER_SUIT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD_POS,
        ST_RD_PART,
        ST_WR_POS,
        ST_WR_PART,
        ST_DEAL
    } state_t;

    state_t                state_reg;
    logic [HAND_W-1:0]     hand_size_reg;
    logic [WORD_W-1:0]     word_reg;
    logic [BCW-1:0]        bit_cnt_reg;
    logic [AW-1:0]         pos_reg;
    logic [CW-1:0]         div_reg;
    logic [AW-1:0]         rem_reg;
    logic [CODE_W-1:0]     a_reg;
    logic [AW-1:0]         deal_idx_reg;
    logic [CW-1:0]         count_reg;
    logic [DECK_SIZE-1:0]  valid_reg;
    logic [AW-1:0]         rd_addr_reg;
    logic                  rd_hit_reg;
    logic                  rd_pending_reg;
    logic                  rd_last_reg;
    logic                  card_valid_reg;
    logic [CODE_W-1:0]     card_code_reg;
    logic [SUIT_W-1:0]     suit_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic                  last_card_reg;

    logic [CW-1:0]         trial;
    logic [AW-1:0]         rem_step;
    logic [AW-1:0]         pos_eff;
    logic [CW-1:0]         count_eff;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [CODE_W-1:0]     ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [CODE_W-1:0]     ram_rdata;
    logic [CODE_W-1:0]     rd_word;
    logic [CODE_W:0]       code_ext;
    logic [SUIT_W-1:0]     suit_dec;
    logic [CODE_W:0]       suit_base;
    logic                  deal_last;

    fycs_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DECK_SIZE)
    ) u_deck (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // restoring remainder, one dividend bit per cycle
    assign trial    = {rem_reg, word_reg[WORD_W-1]};
    assign rem_step = (trial >= div_reg) ? AW'(trial - div_reg) : AW'(trial);

    assign pos_eff = (pos_reg == '0 || {1'b0, pos_reg} >= DECK_C) ? TOP_POS : pos_reg;

    always_comb
    begin
        if (hand_size_reg == '0)
        begin
            count_eff = CW'(1);
        end
        else if ({1'b0, hand_size_reg} > (HAND_W+1)'(DECK_SIZE))
        begin
            count_eff = DECK_C;
        end
        else
        begin
            count_eff = CW'(hand_size_reg);
        end
    end

    // unwritten entries read as their own index
    assign rd_word = rd_hit_reg ? ram_rdata : CODE_W'(rd_addr_reg);

    always_comb
    begin
        unique case (state_reg)
            ST_RD_PART: ram_raddr = rem_reg;
            ST_DEAL:    ram_raddr = deal_idx_reg;
            default:    ram_raddr = pos_reg;
        endcase
        ram_we    = (state_reg == ST_WR_POS) || (state_reg == ST_WR_PART);
        ram_waddr = (state_reg == ST_WR_POS) ? pos_reg : rem_reg;
        ram_wdata = (state_reg == ST_WR_POS) ? rd_word : a_reg;
    end

    // suit and rank by compare against multiples of the rank count
    always_comb
    begin
        code_ext = {1'b0, rd_word};
        if (SUIT_COUNT > 3 && code_ext >= R3)
        begin
            suit_dec  = SUIT_W'(3);
            suit_base = R3;
        end
        else if (SUIT_COUNT > 2 && code_ext >= R2)
        begin
            suit_dec  = SUIT_W'(2);
            suit_base = R2;
        end
        else if (SUIT_COUNT > 1 && code_ext >= R1)
        begin
            suit_dec  = SUIT_W'(1);
            suit_base = R1;
        end
        else
        begin
            suit_dec  = '0;
            suit_base = '0;
        end
    end

    assign deal_last = ({1'b0, deal_idx_reg} + CW'(1)) == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hand_size_reg  <= HAND_W'(5);
            word_reg       <= '0;
            bit_cnt_reg    <= '0;
            pos_reg        <= TOP_POS;
            div_reg        <= '0;
            rem_reg        <= '0;
            a_reg          <= '0;
            deal_idx_reg   <= '0;
            count_reg      <= '0;
            valid_reg      <= '0;
            rd_addr_reg    <= '0;
            rd_hit_reg     <= 1'b0;
            rd_pending_reg <= 1'b0;
            rd_last_reg    <= 1'b0;
            card_valid_reg <= 1'b0;
            card_code_reg  <= '0;
            suit_reg       <= '0;
            rank_reg       <= '0;
            last_card_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                hand_size_reg <= cfg_wdata;
            end

            rd_addr_reg    <= ram_raddr;
            rd_hit_reg     <= valid_reg[ram_raddr];
            rd_pending_reg <= (state_reg == ST_DEAL);

            // output stage
            card_valid_reg <= rd_pending_reg;
            if (rd_pending_reg)
            begin
                card_code_reg <= rd_word;
                suit_reg      <= suit_dec;
                rank_reg      <= RANK_W'(code_ext - suit_base);
                last_card_reg <= rd_last_reg;
            end

            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        word_reg    <= random_word;
                        bit_cnt_reg <= BCW'(WORD_W - 1);
                        pos_reg     <= pos_eff;
                        div_reg     <= {1'b0, pos_eff} + CW'(1);
                        rem_reg     <= '0;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg     <= rem_step;
                    word_reg    <= {word_reg[WORD_W-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg - BCW'(1);
                    if (bit_cnt_reg == '0)
                    begin
                        state_reg <= ST_RD_POS;
                    end
                end
                ST_RD_POS:
                begin
                    state_reg <= ST_RD_PART;
                end
                ST_RD_PART:
                begin
                    a_reg     <= rd_word;
                    state_reg <= ST_WR_POS;
                end
                ST_WR_POS:
                begin
                    state_reg <= ST_WR_PART;
                end
                ST_WR_PART:
                begin
                    if (pos_reg > AW'(1))
                    begin
                        pos_reg   <= pos_reg - AW'(1);
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        deal_idx_reg <= '0;
                        count_reg    <= count_eff;
                        state_reg    <= ST_DEAL;
                    end
                end
                ST_DEAL:
                begin
                    rd_last_reg    <= deal_last;
                    deal_idx_reg   <= deal_idx_reg + AW'(1);
                    if (deal_last)
                    begin
                        // back to identity and top position
                        valid_reg <= '0;
                        pos_reg   <= TOP_POS;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign card_valid = card_valid_reg;
    assign card_code  = card_code_reg;
    assign suit       = suit_reg;
    assign rank       = rank_reg;
    assign last_card  = last_card_reg;

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> {1'b0, rem_reg} < div_reg)
        else $error("remainder not below divisor");

    a_pos_steps_down: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WR_PART && pos_reg > AW'(1) |=> pos_reg == $past(pos_reg) - AW'(1))
        else $error("swap position did not step down");

    a_card_in_deck: assert property (@(posedge clk) disable iff (!rst_n)
        card_valid_reg |-> {1'b0, card_code_reg} < (CODE_W+1)'(DECK_SIZE))
        else $error("dealt card outside deck");

    a_last_ends_hand: assert property (@(posedge clk) disable iff (!rst_n)
        card_valid_reg && last_card_reg |=> !card_valid_reg && state_reg != ST_DEAL)
        else $error("cards after last card");

    a_no_write_while_dealing: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pending_reg |-> !ram_we)
        else $error("deck written during deal");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import fycs_pkg::*;

    localparam int SUIT_COUNT     = 4;
    localparam int RANKS_PER_SUIT = 13;
    localparam int DECK_SIZE      = SUIT_COUNT * RANKS_PER_SUIT;
    localparam int SETTLE_CYCLES  = 48;
    localparam int RANDOM_STEPS   = 66;
    localparam int PLAN_ROWS      = 5;
    localparam int MID_STEP       = 25;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [SUIT_W-1:0] suit;
        logic [RANK_W-1:0] rank;
        logic              last;
    } card_t;

    typedef enum logic [1:0] {
        WP_KEEP,
        WP_CONST,
        WP_ALT
    } word_pattern_t;

    typedef struct packed {
        logic               pre_write;
        logic [HAND_W-1:0]  pre_hand;
        logic               mid_write;
        logic [HAND_W-1:0]  mid_hand;
        word_pattern_t      pattern;
        logic [WORD_W-1:0]  word_value;
        logic               first_typed;
        card_t              first_card;
    } shuffle_plan_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [WORD_W-1:0] random_word;
    logic              cfg_we;
    logic [HAND_W-1:0] cfg_wdata;
    logic              card_valid;
    logic [CODE_W-1:0] card_code;
    logic [SUIT_W-1:0] suit;
    logic [RANK_W-1:0] rank;
    logic              last_card;

    // shadow deck, position and hand size
    logic [CODE_W-1:0] deck_model [DECK_SIZE];
    int unsigned       pos_model;
    logic [HAND_W-1:0] hand_model;

    card_t         hand_cards_q [$];
    shuffle_plan_t directed_plan [PLAN_ROWS];

    int error_count;
    int steps_sent;
    int hands_dealt;
    int cards_checked;
    int idle_pct;

    fisher_yates_card_shuffler_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .random_word (random_word),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .card_valid  (card_valid),
        .card_code   (card_code),
        .suit        (suit),
        .rank        (rank),
        .last_card   (last_card)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic restore_deck();
        for (int k = 0; k < DECK_SIZE; k++)
        begin
            deck_model[k] = CODE_W'(k);
        end
        pos_model = DECK_SIZE - 1;
    endtask

    // one swap step; the step at position 1 deals the hand
    task automatic apply_shuffle_step(input logic [WORD_W-1:0] w);
        int unsigned       wide_word;
        int unsigned       partner;
        int unsigned       count;
        logic [CODE_W-1:0] held;
        card_t             c;
        wide_word = w;
        partner = wide_word % (pos_model + 1);
        held = deck_model[pos_model];
        deck_model[pos_model] = deck_model[partner];
        deck_model[partner] = held;
        if (pos_model > 1)
        begin
            pos_model--;
            return;
        end
        count = hand_model;
        if (count < 1)
            count = 1;
        if (count > DECK_SIZE)
            count = DECK_SIZE;
        for (int unsigned i = 0; i < count; i++)
        begin
            c.code = deck_model[i];
            c.suit = SUIT_W'(deck_model[i] / RANKS_PER_SUIT);
            c.rank = RANK_W'(deck_model[i] % RANKS_PER_SUIT);
            c.last = (i + 1 == count);
            hand_cards_q.push_back(c);
        end
        restore_deck();
        hands_dealt++;
    endtask

    task automatic send_word(input logic [WORD_W-1:0] w);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start       = 1'b1;
        random_word = w;
        do
            @(posedge clk);
        while (busy);
        apply_shuffle_step(w);
        steps_sent++;
    endtask

    // drain all pending cards and let the block go quiet
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (hand_cards_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_hand(input logic [HAND_W-1:0] v);
        @(negedge clk);
        cfg_we     = 1'b1;
        cfg_wdata  = v;
        hand_model = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [HAND_W-1:0] pick_hand();
        case ($urandom_range(9))
            7:       return '0;
            8:       return HAND_W'(DECK_SIZE);
            9:       return HAND_W'($urandom_range(DECK_SIZE + 1, 63));
            default: return HAND_W'($urandom_range(1, DECK_SIZE));
        endcase
    endfunction

    // card check, one transaction per strobe
    always @(posedge clk)
    begin
        card_t exp_card;
        if (rst_n && card_valid)
        begin
            if (hand_cards_q.size() == 0)
            begin
                $error("card with no expectation: code %0d", card_code);
                error_count++;
            end
            else
            begin
                exp_card = hand_cards_q.pop_front();
                cards_checked++;
                if (card_code !== exp_card.code)
                begin
                    $error("card_code: expected %0d, actual %0d", exp_card.code, card_code);
                    error_count++;
                end
                if (suit !== exp_card.suit)
                begin
                    $error("suit: expected %0d, actual %0d", exp_card.suit, suit);
                    error_count++;
                end
                if (rank !== exp_card.rank)
                begin
                    $error("rank: expected %0d, actual %0d", exp_card.rank, rank);
                    error_count++;
                end
                if (last_card !== exp_card.last)
                begin
                    $error("last_card: expected %0d, actual %0d", exp_card.last, last_card);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        logic [WORD_W-1:0] w;
        int                first_idx;
        int                random_steps;

        rst_n         = 1'b0;
        start         = 1'b0;
        random_word   = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        error_count   = 0;
        steps_sent    = 0;
        hands_dealt   = 0;
        cards_checked = 0;
        idle_pct      = 24;
        first_idx     = 0;
        hand_model    = HAND_W'(5);
        restore_deck();

        // identity kept, reset hand size
        directed_plan[0] = '{1'b0, '0, 1'b0, '0, WP_KEEP, '0,
                             1'b1, '{6'd0, 2'd0, 4'd0, 1'b0}};
        // zero words rotate the deck by one, hand size zero deals one card
        directed_plan[1] = '{1'b1, 6'd0, 1'b0, '0, WP_CONST, 31'h0,
                             1'b1, '{6'd1, 2'd0, 4'd1, 1'b1}};
        // hand size above the deck, whole identity deck dealt
        directed_plan[2] = '{1'b1, 6'd63, 1'b0, '0, WP_KEEP, '0,
                             1'b1, '{6'd0, 2'd0, 4'd0, 1'b0}};
        directed_plan[3] = '{1'b1, 6'd52, 1'b0, '0, WP_CONST, 31'h7FFF_FFFF,
                             1'b0, '{6'd0, 2'd0, 4'd0, 1'b0}};
        // hand size changed halfway through the shuffle
        directed_plan[4] = '{1'b1, 6'd1, 1'b1, 6'd40, WP_ALT, 31'h5555_5555,
                             1'b0, '{6'd0, 2'd0, 4'd0, 1'b0}};

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            settle();
            if (directed_plan[r].pre_write)
                write_hand(directed_plan[r].pre_hand);
            for (int s = 0; s < DECK_SIZE - 1; s++)
            begin
                if (directed_plan[r].mid_write && s == MID_STEP)
                begin
                    settle();
                    write_hand(directed_plan[r].mid_hand);
                end
                case (directed_plan[r].pattern)
                    WP_KEEP:  w = WORD_W'(pos_model);
                    WP_CONST: w = directed_plan[r].word_value;
                    default:  w = s[0] ? ~directed_plan[r].word_value
                                       : directed_plan[r].word_value;
                endcase
                if (s == DECK_SIZE - 2)
                    first_idx = hand_cards_q.size();
                send_word(w);
            end
            if (directed_plan[r].first_typed)
                hand_cards_q[first_idx] = directed_plan[r].first_card;
        end

        random_steps = 0;
        while (random_steps < RANDOM_STEPS)
        begin
            if (random_steps < RANDOM_STEPS / 3)
                idle_pct = 24;
            else if (random_steps < 2 * RANDOM_STEPS / 3)
                idle_pct = 66;
            else
                idle_pct = 0;
            if (pos_model == DECK_SIZE - 1 && $urandom_range(1) == 1)
            begin
                settle();
                write_hand(pick_hand());
            end
            else if (pos_model == 20 && $urandom_range(3) == 0)
            begin
                settle();
                write_hand(pick_hand());
            end
            case ($urandom_range(9))
                6:       w = WORD_W'($urandom_range(0, 60));
                7:       w = WORD_W'(pos_model);
                8:       w = WORD_W'(pos_model + 1);
                9:       w = $urandom_range(1) ? '1 : '0;
                default: w = WORD_W'($urandom());
            endcase
            send_word(w);
            random_steps++;
        end

        settle();
        if (hand_cards_q.size() != 0)
        begin
            $error("%0d expected cards never dealt", hand_cards_q.size());
            error_count++;
        end
        $display("run covered %0d shuffle steps, %0d hands dealt, %0d cards compared",
                 steps_sent, hands_dealt, cards_checked);
        $display("hand sizes from zero to 63, sender idle at 24, 66 and 0 percent");
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
